// ----- rtl/bfir_pkg.sv -----
package bfir_pkg;

  typedef struct packed {
    logic        command;
    logic [15:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [7:0]  result_x;
    logic [7:0]  result_y;
    logic        frame_last;
  } out_word_t;

  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_TARGET_WIDTH  = 3'd2,
    REG_TARGET_HEIGHT = 3'd3,
    REG_SAMPLE_MODE   = 3'd4
  } reg_index_t;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEPC,
    S_STEPC_WAIT,
    S_STEPR,
    S_STEPR_WAIT,
    S_BOX,
    S_BASE,
    S_READ,
    S_DRAIN,
    S_MEAN,
    S_MEAN_WAIT,
    S_SEARCH,
    S_EMIT
  } state_t;

  localparam int MAX_SIDE = 256;

  localparam int DIV_W = 34;
  localparam int DVS_W = 18;

  typedef logic [15:0] tab_t [256];

  localparam logic [63:0] Q30One = 64'd1 << 30;
  localparam logic [63:0] LinDen = 64'd255;
  localparam logic [63:0] ThrDen = 64'd255999;

  // shift-subtract quotient, used only while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] pow5_q30(input logic [63:0] y);
    logic [63:0] p;
    p = y;
    for (int i = 0; i < 4; i++) p = (p * y) >> 30;
    return p;
  endfunction

  // t^2.4 = t^2 * t^0.4, fifth root by bitwise search
  function automatic logic [63:0] gamma_tail(input logic [63:0] t_in);
    logic [63:0] t, t2, y, c;
    t = (t_in > Q30One) ? Q30One : t_in;
    t2 = (t * t) >> 30;
    y = '0;
    for (int b = 30; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (c <= Q30One && pow5_q30(c) <= t2) y = c;
    end
    return (t2 * y) >> 30;
  endfunction

  function automatic logic [63:0] lin_q30(input logic [63:0] num);
    if (num * 64'd100000 <= LinDen * 64'd4045)
      return udiv64((num * 64'd100) << 30, 64'd1292 * LinDen);
    return gamma_tail(udiv64((num * 64'd1000 + LinDen * 64'd55) << 30, 64'd1055 * LinDen));
  endfunction

  function automatic logic [63:0] thr_q30(input logic [63:0] num);
    if (num * 64'd100000 <= ThrDen * 64'd4045)
      return udiv64((num * 64'd100) << 30, 64'd1292 * ThrDen);
    return gamma_tail(udiv64((num * 64'd1000 + ThrDen * 64'd55) << 30, 64'd1055 * ThrDen));
  endfunction

  function automatic tab_t build_lin();
    tab_t t;
    logic [63:0] l;
    for (int k = 0; k < 256; k++) begin
      l = lin_q30(64'(k));
      t[k] = 16'((l * 64'd65535 + (64'd1 << 29)) >> 30);
    end
    return t;
  endfunction

  function automatic tab_t build_thr();
    tab_t t;
    logic [63:0] m;
    for (int k = 0; k < 256; k++) begin
      m = thr_q30(64'd1000 * 64'(k));
      t[k] = 16'((m * 64'd65535 + Q30One - 64'd1) >> 30);
    end
    return t;
  endfunction

  localparam tab_t LIN_TABLE = build_lin();
  localparam tab_t THR_TABLE = build_thr();

endpackage

// ----- rtl/bfir_store.sv -----
module bfir_store #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bfir_div.sv -----
module bfir_div import bfir_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVS_W:0]   trial;

  assign trial = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= DVS_W'(trial - {1'b0, dvs});
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DVS_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/box_filter_image_rescaler.sv -----
// channel | direction | handshake          | word
// in      | input     | in_valid/in_ready  | in_word_t: command, pixel_value
// out     | output    | out_valid/out_ready| out_word_t: value, x, y, frame_last
// cfg     | input     | cfg_we             | cfg_index, cfg_data
// A store is accepted only while idle. An emit first runs the two step divisions
// on a frame's first pixel, reads the W*H pixels of its box (one store read per
// cycle), takes the mean on the radix-2 divider and searches the table if mode is 0.
// Reset is synchronous; no clearing pass, the store is undefined until loaded.
// A finished word waits in the output register while the next word is taken;
// an emit stalls only at its end if that register is still full.
module box_filter_image_rescaler import bfir_pkg::*; #(
  parameter int STORE_DEPTH   = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = FRACTION_BITS + 19;
  localparam int RW = PW - FRACTION_BITS + 1;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRACTION_BITS - 1);

  function automatic logic [8:0] eff_size(input logic [8:0] v);
    if (v == 9'd0) return 9'd1;
    if (int'(v) > MAX_SIDE) return 9'(MAX_SIDE);
    return v;
  endfunction

  function automatic logic [8:0] rnd(input logic [PW-1:0] pos, input logic [8:0] size);
    logic [PW:0]   s;
    logic [RW-1:0] r;
    s = {1'b0, pos} + HALF;
    r = s[PW:FRACTION_BITS];
    if (r > RW'(size - 9'd1)) return size - 9'd1;
    return 9'(r);
  endfunction

  state_t state, state_next;

  logic [8:0] src_w, src_h, tgt_w, tgt_h;
  logic       mode;
  logic [8:0] sw_e, sh_e, tw_e, th_e;

  logic [15:0]   load_index;
  logic [PW-1:0] col_pos, row_pos, col_step, row_step;
  logic [8:0]    out_col, out_row;
  logic [8:0]    x0, x1, y0, y1, x, y;
  logic [17:0]   row_addr;
  logic [31:0]   sum;
  logic [16:0]   cnt;
  logic          rd_pending;
  logic [DIV_W-1:0] mean;
  logic [7:0]    k;
  logic [2:0]    bitn;
  logic [7:0]    k_try;

  logic          in_acc, mem_we, mem_re, div_start, div_done, emit_load;
  logic [15:0]   rdata, sample;
  logic [AW-1:0] waddr, raddr;
  logic [DIV_W-1:0] div_a, div_q;
  logic [DVS_W-1:0] div_b;
  logic [17:0]   area;

  assign sw_e = eff_size(src_w);
  assign sh_e = eff_size(src_h);
  assign tw_e = eff_size(tgt_w);
  assign th_e = eff_size(tgt_h);
  assign in_acc = in_valid && in_ready;
  assign area = 18'(sw_e) * 18'(sh_e);
  assign waddr = AW'(load_index);
  assign raddr = AW'(row_addr + 18'(x));
  assign sample = mode ? rdata : LIN_TABLE[rdata[7:0]];
  assign k_try = k | (8'd1 << bitn);
  assign emit_load = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && in_data.command == CMD_EMIT)
          state_next = (out_col == 9'd0 && out_row == 9'd0) ? S_STEPC : S_BOX;
      end
      S_STEPC:      state_next = S_STEPC_WAIT;
      S_STEPC_WAIT: if (div_done) state_next = S_STEPR;
      S_STEPR:      state_next = S_STEPR_WAIT;
      S_STEPR_WAIT: if (div_done) state_next = S_BOX;
      S_BOX:        state_next = S_BASE;
      S_BASE:       state_next = S_READ;
      S_READ:       if (x == x1 && y == y1) state_next = S_DRAIN;
      S_DRAIN:      state_next = S_MEAN;
      S_MEAN:       state_next = S_MEAN_WAIT;
      S_MEAN_WAIT:  if (div_done) state_next = mode ? S_EMIT : S_SEARCH;
      S_SEARCH:     if (bitn == 3'd0) state_next = S_EMIT;
      S_EMIT:       if (emit_load) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    mem_we    = in_acc && in_data.command == CMD_STORE;
    mem_re    = (state == S_READ);
    div_start = (state == S_STEPC) || (state == S_STEPR) || (state == S_MEAN);
    div_a     = '0;
    div_b     = '0;
    case (state)
      S_STEPC: begin
        div_a = DIV_W'(sw_e) << FRACTION_BITS;
        div_b = DVS_W'(tw_e);
      end
      S_STEPR: begin
        div_a = DIV_W'(sh_e) << FRACTION_BITS;
        div_b = DVS_W'(th_e);
      end
      S_MEAN: begin
        div_a = mode ? (DIV_W'(sum) << 1) + DIV_W'(cnt) : DIV_W'(sum);
        div_b = mode ? {cnt, 1'b0} : DVS_W'(cnt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      src_w      <= 9'd1;
      src_h      <= 9'd1;
      tgt_w      <= 9'd1;
      tgt_h      <= 9'd1;
      mode       <= 1'b0;
      load_index <= '0;
      col_pos    <= '0;
      row_pos    <= '0;
      col_step   <= '0;
      row_step   <= '0;
      out_col    <= '0;
      out_row    <= '0;
      out_valid  <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= (state == S_READ);
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:  src_w <= cfg_data;
          REG_SOURCE_HEIGHT: src_h <= cfg_data;
          REG_TARGET_WIDTH:  tgt_w <= cfg_data;
          REG_TARGET_HEIGHT: tgt_h <= cfg_data;
          REG_SAMPLE_MODE:   mode  <= cfg_data[0];
          default: ;
        endcase
      end
      if (mem_we)
        load_index <= (18'(load_index) + 18'd1 >= area) ? '0 : load_index + 16'd1;
      if (state == S_STEPC_WAIT && div_done) begin
        col_step <= PW'(div_q);
        col_pos  <= '0;
      end
      if (state == S_STEPR_WAIT && div_done) begin
        row_step <= PW'(div_q);
        row_pos  <= '0;
      end
      if (emit_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (emit_load) begin
        if (out_col + 9'd1 >= tw_e) begin
          out_col <= '0;
          col_pos <= '0;
          if (out_row + 9'd1 >= th_e) begin
            out_row <= '0;
            row_pos <= '0;
          end else begin
            out_row <= out_row + 9'd1;
            row_pos <= row_pos + row_step;
          end
        end else begin
          out_col <= out_col + 9'd1;
          col_pos <= col_pos + col_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BOX) begin
      x0 <= rnd(col_pos, sw_e);
      x1 <= rnd(col_pos + col_step, sw_e);
      y0 <= rnd(row_pos, sh_e);
      y1 <= rnd(row_pos + row_step, sh_e);
    end
    if (state == S_BASE) begin
      row_addr <= 18'(y0) * 18'(sw_e);
      x        <= x0;
      y        <= y0;
      sum      <= '0;
      cnt      <= '0;
    end else begin
      if (state == S_READ) begin
        if (x == x1) begin
          x        <= x0;
          y        <= y + 9'd1;
          row_addr <= row_addr + 18'(sw_e);
        end else begin
          x <= x + 9'd1;
        end
      end
      if (rd_pending) begin
        sum <= sum + 32'(sample);
        cnt <= cnt + 17'd1;
      end
    end
    if (state == S_MEAN_WAIT && div_done) begin
      mean <= div_q;
      k    <= '0;
      bitn <= 3'd7;
    end
    if (state == S_SEARCH) begin
      if (mean >= DIV_W'(THR_TABLE[k_try])) k <= k_try;
      bitn <= bitn - 3'd1;
    end
    if (emit_load) begin
      out_data.result_value <= mode ? mean[15:0] : {8'd0, k};
      out_data.result_x     <= out_col[7:0];
      out_data.result_y     <= out_row[7:0];
      out_data.frame_last   <= (out_col + 9'd1 >= tw_e) && (out_row + 9'd1 >= th_e);
    end
  end

  bfir_store #(.AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (in_data.pixel_value),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  bfir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    state == S_BASE |-> (x0 <= x1 && y0 <= y1))
    else $error("box corners out of order");

  a_walk_in_box: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> (x <= x1 && y <= y1))
    else $error("read walk left the box");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_MEAN |-> cnt != 17'd0)
    else $error("mean of an empty box");

endmodule
